// File: hdl/xdnt_pkg.sv
// Package: shared types and constants of the XOR-distance node table.
`timescale 1ns / 1ps
package xdnt_pkg;
	localparam int IdHighW = 32;
	localparam int IdWideW = 64;
	localparam int AddrW   = 32;
	localparam int PortW   = 16;
	localparam int OpW     = 3;
	localparam int StatusW = 3;
	localparam int CountW  = 4;
	localparam int IdW     = IdHighW + 2 * IdWideW;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 64;

	localparam logic [OpW-1:0] OP_INSERT  = 3'd0;
	localparam logic [OpW-1:0] OP_REMOVE  = 3'd1;
	localparam logic [OpW-1:0] OP_FIND    = 3'd2;
	localparam logic [OpW-1:0] OP_CLOSEST = 3'd3;
	localparam logic [OpW-1:0] OP_COUNT   = 3'd4;

	localparam logic [StatusW-1:0] ST_OK       = 3'd0;
	localparam logic [StatusW-1:0] ST_OWN_ID   = 3'd1;
	localparam logic [StatusW-1:0] ST_FULL     = 3'd2;
	localparam logic [StatusW-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [StatusW-1:0] ST_NONE     = 3'd4;

	localparam logic [CfgIdxW-1:0] REG_OWN_HIGH = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_OWN_MID  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_OWN_LOW  = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_CAPACITY = 2'd3;

	localparam int MaxResults = 8;

	typedef struct packed {
		logic [OpW-1:0]     op;
		logic [IdHighW-1:0] id_high;
		logic [IdWideW-1:0] id_middle;
		logic [IdWideW-1:0] id_low;
		logic [AddrW-1:0]   address;
		logic [PortW-1:0]   port;
		logic [CountW-1:0]  wanted;
	} req_t;

	typedef struct packed {
		logic [StatusW-1:0] status;
		logic               entry_valid;
		logic [IdHighW-1:0] out_id_high;
		logic [IdWideW-1:0] out_id_middle;
		logic [IdWideW-1:0] out_id_low;
		logic [AddrW-1:0]   out_address;
		logic [PortW-1:0]   out_port;
		logic [CountW-1:0]  used_count;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic [CfgIdxW-1:0]  index;
		logic [CfgDataW-1:0] data;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture request
		logic scan_clr;   // restart the scan (clear pointer and results)
		logic scan_step;  // examine one slot
		logic do_insert;  // commit insert/update
		logic do_remove;
		logic pick_take;  // mark current best as taken
		logic emit;       // load result register
		logic [StatusW-1:0] status;
		logic with_entry;
		logic last;
	} dp_cmd_t;
endpackage

// File: hdl/xdnt_if.sv
// Interface: valid/ready channel carrying one payload type.
`timescale 1ns / 1ps
interface xdnt_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/xdnt_datapath.sv
// Datapath: slot storage, request register, serial scan and result register.
`timescale 1ns / 1ps
module xdnt_datapath import xdnt_pkg::*; #(
	parameter int Depth = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        req,
	input  cfg_t        cfg,
	input  logic        cfg_we,
	input  dp_cmd_t     cmd,
	output req_t        req_q,
	output logic [$clog2(Depth+1)-1:0] used_q,
	output logic        scan_done,
	output logic        match_found,
	output logic        own_hit,
	output logic        full,
	output logic        best_found,
	output rsp_t        rsp_q
);
	localparam int SW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth+1);

	logic [Depth-1:0] valid_q;
	logic [Depth-1:0] taken_q;
	logic [IdW-1:0]   id_mem [Depth];
	logic [AddrW-1:0] addr_mem [Depth];
	logic [PortW-1:0] port_mem [Depth];
	logic [IdW-1:0]   own_q;
	logic [CountW-1:0] cap_q;
	logic [SW-1:0]    ptr_q;
	logic             done_q;
	logic             hit_q;
	logic [SW-1:0]    hit_slot_q;
	logic             best_q;
	logic [SW-1:0]    best_slot_q;
	logic [IdW-1:0]   best_dist_q;
	logic [IdW-1:0]   key;
	logic [IdW-1:0]   slot_dist;
	logic [SW-1:0]    free_slot;
	logic             free_any;
	logic [CW-1:0]    limit;

	assign key = {req_q.id_high, req_q.id_middle, req_q.id_low};
	assign slot_dist = id_mem[ptr_q] ^ key;
	assign own_hit = (key == own_q);
	assign scan_done = done_q;
	assign match_found = hit_q;
	assign best_found = best_q;

	always_comb begin
		free_slot = '0;
		free_any = 1'b0;
		for (int i = Depth - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = SW'(i);
				free_any = 1'b1;
			end
		end
		if (int'(cap_q) > Depth)
			limit = CW'(Depth);
		else
			limit = CW'(cap_q);
		full = (used_q >= limit) || !free_any;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
			cap_q <= CountW'(8);
		end else if (cfg_we) begin
			case (cfg.index)
				REG_OWN_HIGH: own_q[IdW-1 -: IdHighW] <= cfg.data[IdHighW-1:0];
				REG_OWN_MID:  own_q[2*IdWideW-1 -: IdWideW] <= cfg.data;
				REG_OWN_LOW:  own_q[IdWideW-1:0] <= cfg.data;
				REG_CAPACITY: cap_q <= cfg.data[CountW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			taken_q     <= '0;
			used_q      <= '0;
			ptr_q       <= '0;
			done_q      <= 1'b0;
			hit_q       <= 1'b0;
			hit_slot_q  <= '0;
			best_q      <= 1'b0;
			best_slot_q <= '0;
			best_dist_q <= '0;
		end else begin
			if (cmd.load) taken_q <= '0;
			if (cmd.scan_clr) begin
				ptr_q  <= '0;
				done_q <= 1'b0;
				hit_q  <= 1'b0;
				best_q <= 1'b0;
			end else if (cmd.scan_step && !done_q) begin
				if (valid_q[ptr_q] && id_mem[ptr_q] == key) begin
					hit_q <= 1'b1;
					hit_slot_q <= ptr_q;
				end
				if (valid_q[ptr_q] && !taken_q[ptr_q] &&
				    (!best_q || slot_dist < best_dist_q)) begin
					best_q <= 1'b1;
					best_slot_q <= ptr_q;
					best_dist_q <= slot_dist;
				end
				if (ptr_q == SW'(Depth - 1)) done_q <= 1'b1;
				else ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.pick_take) taken_q[best_slot_q] <= 1'b1;
			if (cmd.do_insert && !hit_q) begin
				valid_q[free_slot] <= 1'b1;
				used_q <= used_q + 1'b1;
			end
			if (cmd.do_remove && hit_q) begin
				valid_q[hit_slot_q] <= 1'b0;
				used_q <= used_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_insert) begin
			if (hit_q) begin
				addr_mem[hit_slot_q] <= req_q.address;
				port_mem[hit_slot_q] <= req_q.port;
			end else begin
				id_mem[free_slot]   <= key;
				addr_mem[free_slot] <= req_q.address;
				port_mem[free_slot] <= req_q.port;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			logic [SW-1:0] s;
			s = (req_q.op == OP_CLOSEST) ? best_slot_q : hit_slot_q;
			rsp_q.status <= cmd.status;
			rsp_q.entry_valid <= cmd.with_entry;
			rsp_q.used_count <= CountW'(used_q);
			rsp_q.last <= cmd.last;
			if (cmd.with_entry) begin
				{rsp_q.out_id_high, rsp_q.out_id_middle, rsp_q.out_id_low} <= id_mem[s];
				rsp_q.out_address <= addr_mem[s];
				rsp_q.out_port <= port_mem[s];
			end else begin
				{rsp_q.out_id_high, rsp_q.out_id_middle, rsp_q.out_id_low} <= '0;
				rsp_q.out_address <= '0;
				rsp_q.out_port <= '0;
			end
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(Depth)) else $error("used count overflow");
	a_used_ones: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(used_q)) else $error("used count mismatch");
	a_taken_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(taken_q & ~valid_q) == '0) else $error("taken slot not valid");
endmodule

// File: hdl/xdnt_ctrl.sv
// Controller: sequences scans, table updates and result transfers.
`timescale 1ns / 1ps
module xdnt_ctrl import xdnt_pkg::*; #(
	parameter int Depth = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  req_t    req_q,
	input  logic [$clog2(Depth+1)-1:0] used_q,
	input  logic    scan_done,
	input  logic    match_found,
	input  logic    own_hit,
	input  logic    full,
	input  logic    best_found,
	output dp_cmd_t cmd
);
	localparam int CW = $clog2(Depth+1);
	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_EMIT, S_WAIT, S_NEXT} state_t;
	state_t state_q;
	logic [CW-1:0] left_q;
	logic [StatusW-1:0] st_q;
	logic [CW-1:0] n;

	always_comb begin
		if (int'(req_q.wanted) < int'(used_q)) n = CW'(req_q.wanted);
		else n = used_q;
		if (int'(n) > MaxResults) n = CW'(MaxResults);
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.scan_clr = cmd.load || (state_q == S_NEXT);
		cmd.scan_step = (state_q == S_SCAN);
		in_ready = (state_q == S_IDLE);
		cmd.last = 1'b1;
		cmd.status = ST_OK;
		if (state_q == S_DECIDE) begin
			cmd.emit = 1'b1;
			case (req_q.op)
				OP_INSERT: begin
					if (own_hit) cmd.status = ST_OWN_ID;
					else if (!match_found && full) cmd.status = ST_FULL;
					else cmd.do_insert = 1'b1;
					cmd.emit = 1'b0;
				end
				OP_REMOVE: begin
					cmd.do_remove = 1'b1;
					cmd.emit = 1'b0;
				end
				OP_FIND: begin
					cmd.status = match_found ? ST_OK : ST_NOTFOUND;
					cmd.with_entry = match_found;
				end
				OP_CLOSEST: begin
					if (left_q == '0) cmd.status = ST_NONE;
					else begin
						cmd.with_entry = best_found;
						cmd.pick_take = 1'b1;
						cmd.last = (left_q == CW'(1));
					end
				end
				default: ;
			endcase
		end
		if (state_q == S_EMIT) begin
			cmd.emit = 1'b1;
			if (req_q.op == OP_INSERT) begin
				cmd.status = st_q;
			end else if (req_q.op == OP_REMOVE) begin
				cmd.status = match_found ? ST_OK : ST_NOTFOUND;
			end
		end
		out_valid = (state_q == S_WAIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			left_q  <= '0;
			st_q    <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SCAN;
				S_SCAN: if (scan_done) begin
					state_q <= S_DECIDE;
					if (req_q.op == OP_CLOSEST && left_q == '0 && !cmd.pick_take)
						left_q <= n;
				end
				S_DECIDE: begin
					st_q <= cmd.status;
					if (req_q.op == OP_INSERT || req_q.op == OP_REMOVE) state_q <= S_EMIT;
					else state_q <= S_WAIT;
					if (req_q.op == OP_CLOSEST && left_q != '0) left_q <= left_q - 1'b1;
				end
				S_EMIT: state_q <= S_WAIT;
				S_WAIT: if (out_ready) begin
					if (req_q.op == OP_CLOSEST && left_q != '0) state_q <= S_NEXT;
					else state_q <= S_IDLE;
				end
				S_NEXT: state_q <= S_SCAN;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input and output both open");
	a_scan_leads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DECIDE |-> $past(state_q) == S_SCAN) else $error("decide without scan");
	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(left_q) <= MaxResults) else $error("result count overflow");
endmodule

// File: hdl/xor_distance_node_table_top.sv
// Top level: XOR-distance node table with valid/ready channels.
// Closest emits min(wanted,used,8) results, each further one after a fresh scan; with none to give, one ST_NONE result.
// Throughput: one item at a time; next input taken the cycle after the final result transfer.
// Reset: asynchronous, clears valid marks and control registers (not storage, request or result); no clearing pass.
`timescale 1ns / 1ps
module xor_distance_node_table_top import xdnt_pkg::*; #(
	parameter int TABLE_DEPTH = 8
) (
	input logic clk,
	input logic arst_n,
	xdnt_if.sink   req,
	xdnt_if.sink   cfg,
	xdnt_if.source rsp
);
	req_t    req_q;
	dp_cmd_t cmd;
	logic [$clog2(TABLE_DEPTH+1)-1:0] used_q;
	logic    scan_done, match_found, own_hit, full, best_found;
	rsp_t    rsp_q;

	assign cfg.ready = 1'b1;
	assign rsp.data = rsp_q;

	xdnt_datapath #(.Depth(TABLE_DEPTH)) u_dp (
		.clk, .arst_n, .req(req_t'(req.data)), .cfg(cfg_t'(cfg.data)),
		.cfg_we(cfg.valid), .cmd, .req_q, .used_q, .scan_done, .match_found,
		.own_hit, .full, .best_found, .rsp_q
	);

	xdnt_ctrl #(.Depth(TABLE_DEPTH)) u_ctrl (
		.clk, .arst_n, .in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .req_q, .used_q,
		.scan_done, .match_found, .own_hit, .full, .best_found, .cmd
	);
endmodule

// File: bench/tb_xor_distance_node_table_top.sv
// Testbench: node table operations checked against a behavioural table model.
`timescale 1ns / 1ps
module tb_xor_distance_node_table_top;
	import xdnt_pkg::*;

	logic clk = 0;
	logic arst_n = 0;

	xdnt_if #($bits(req_t)) req ();
	xdnt_if #($bits(cfg_t)) cfg ();
	xdnt_if #($bits(rsp_t)) rsp ();

	xor_distance_node_table_top #(.TABLE_DEPTH(8)) uut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .cfg(cfg.sink), .rsp(rsp.source)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// table model
	logic [IdHighW-1:0] own_hi;
	logic [IdWideW-1:0] own_mid, own_lo;
	logic [3:0] capacity;
	logic tab_valid [8];
	logic [IdW-1:0] tab_id [8];
	logic [AddrW-1:0] tab_addr [8];
	logic [PortW-1:0] tab_port [8];

	rsp_t expected_rsp [$];
	int mismatches = 0;
	bit hold_go = 0;
	bit long_hold = 0;
	bit sender_bursty = 1;

	function automatic void add_expected(rsp_t r);
		expected_rsp = {expected_rsp, r};
	endfunction

	function automatic int used_slots();
		int n;
		n = 0;
		for (int i = 0; i < 8; i++) if (tab_valid[i]) n++;
		return n;
	endfunction

	function automatic int find_slot(logic [IdW-1:0] id);
		for (int i = 0; i < 8; i++) if (tab_valid[i] && tab_id[i] == id) return i;
		return -1;
	endfunction

	function automatic rsp_t make_rsp(logic [StatusW-1:0] st, int s, int used, bit lst);
		rsp_t r;
		r = '0;
		r.status = st;
		if (s >= 0) begin
			r.entry_valid = 1;
			{r.out_id_high, r.out_id_middle, r.out_id_low} = tab_id[s];
			r.out_address = tab_addr[s];
			r.out_port = tab_port[s];
		end
		r.used_count = CountW'(used);
		r.last = lst;
		return r;
	endfunction

	task automatic predict_table_op(req_t q);
		logic [IdW-1:0] id;
		int s, n, lim, best;
		bit taken [8];
		id = {q.id_high, q.id_middle, q.id_low};
		if (q.op == OP_INSERT) begin
			s = find_slot(id);
			lim = capacity > 8 ? 8 : capacity;
			if (id == {own_hi, own_mid, own_lo}) begin
				add_expected(make_rsp(ST_OWN_ID, -1, used_slots(), 1));
			end else if (s >= 0) begin
				tab_addr[s] = q.address;
				tab_port[s] = q.port;
				add_expected(make_rsp(ST_OK, -1, used_slots(), 1));
			end else if (used_slots() >= lim) begin
				add_expected(make_rsp(ST_FULL, -1, used_slots(), 1));
			end else begin
				s = 0;
				while (tab_valid[s]) s++;
				tab_valid[s] = 1;
				tab_id[s] = id;
				tab_addr[s] = q.address;
				tab_port[s] = q.port;
				add_expected(make_rsp(ST_OK, -1, used_slots(), 1));
			end
		end else if (q.op == OP_REMOVE) begin
			s = find_slot(id);
			if (s >= 0) tab_valid[s] = 0;
			add_expected(make_rsp(s >= 0 ? ST_OK : ST_NOTFOUND, -1, used_slots(), 1));
		end else if (q.op == OP_FIND) begin
			s = find_slot(id);
			add_expected(make_rsp(s >= 0 ? ST_OK : ST_NOTFOUND, s, used_slots(), 1));
		end else if (q.op == OP_CLOSEST) begin
			n = used_slots();
			if (q.wanted < n) n = q.wanted;
			if (n == 0) begin
				add_expected(make_rsp(ST_NONE, -1, used_slots(), 1));
			end else begin
				for (int i = 0; i < 8; i++) taken[i] = 0;
				for (int k = 0; k < n; k++) begin
					best = -1;
					for (int i = 0; i < 8; i++) begin
						if (!tab_valid[i] || taken[i]) continue;
						if (best < 0 || (tab_id[i] ^ id) < (tab_id[best] ^ id)) best = i;
					end
					taken[best] = 1;
					add_expected(make_rsp(ST_OK, best, used_slots(), k + 1 == n));
				end
			end
		end else begin
			add_expected(make_rsp(ST_OK, -1, used_slots(), 1));
		end
	endtask

	task automatic send_op(req_t q);
		if (sender_bursty && $urandom_range(0, 3) == 0) begin
			req.valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req.valid <= 1;
		req.data <= q;
		do @(posedge clk); while (!req.ready);
		predict_table_op(q);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		cfg.valid <= 1;
		cfg.data <= {idx, val};
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
		case (idx)
			REG_OWN_HIGH: own_hi = val[IdHighW-1:0];
			REG_OWN_MID: own_mid = val;
			REG_OWN_LOW: own_lo = val;
			default: capacity = val[3:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		req.valid <= 0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// small ID pool so that updates, finds and removes hit stored entries
	logic [IdW-1:0] id_pool [12];

	function automatic req_t pool_op(logic [OpW-1:0] op);
		req_t q;
		q.op = op;
		{q.id_high, q.id_middle, q.id_low} = id_pool[$urandom_range(0, 11)];
		q.address = $urandom();
		q.port = PortW'($urandom());
		q.wanted = CountW'($urandom_range(0, 15));
		return q;
	endfunction

	task automatic test_directed();
		req_t q;
		q = '0;
		send_op(q);                         // own ID (zero) rejected
		q.op = OP_CLOSEST; q.wanted = 8;
		send_op(q);                         // none status, no entry
		q.op = OP_FIND; send_op(q);
		q.op = OP_REMOVE; send_op(q);
		for (int i = 0; i < 9; i++) begin
			q.op = OP_INSERT;
			q.id_high = i == 0 ? '1 : i; q.id_middle = (i == 1) ? '1 : '0;
			q.id_low = (i == 2) ? '1 : IdWideW'(i * 3);
			q.address = i == 3 ? '1 : i; q.port = (i == 4) ? '1 : PortW'(i);
			send_op(q);                     // ninth is table full
		end
		q.op = OP_INSERT; q.id_high = 1; q.id_middle = '1; q.id_low = 3;
		q.address = 32'h0a000001; q.port = 16'hffff;
		send_op(q);                         // update while full
		q.op = OP_FIND; send_op(q);
		q.op = OP_CLOSEST; q.wanted = 15; q.id_high = '1; send_op(q);
		q.wanted = 3; send_op(q);
		q.op = OP_COUNT; send_op(q);
		q.op = 3'd5; send_op(q);
		q.op = 3'd7; send_op(q);
		q.op = OP_REMOVE; q.id_high = 1; send_op(q);
		drain();
	endtask

	task automatic test_config();
		req_t q;
		write_reg(REG_OWN_HIGH, 64'hffff_ffff);
		write_reg(REG_OWN_MID, '1);
		write_reg(REG_OWN_LOW, '1);
		write_reg(REG_CAPACITY, 64'd1);
		q = '0; q.op = OP_INSERT; q.id_high = '1; q.id_middle = '1; q.id_low = '1;
		send_op(q);                         // own ID
		q.id_high = 0; send_op(q);
		drain();
		write_reg(REG_CAPACITY, 64'd0);
		q.id_low = 5; send_op(q);           // zero capacity
		drain();
		write_reg(REG_CAPACITY, 64'd15);
		send_op(q);
		drain();
	endtask

	task automatic test_random(int items, int cap);
		req_t q;
		int r;
		write_reg(REG_CAPACITY, CfgDataW'(cap));
		write_reg(REG_OWN_LOW, id_pool[$urandom_range(0, 11)][63:0]);
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(0, 19);
			if (r < 7) q = pool_op(OP_INSERT);
			else if (r < 10) q = pool_op(OP_REMOVE);
			else if (r < 13) q = pool_op(OP_FIND);
			else if (r < 17) q = pool_op(OP_CLOSEST);
			else if (r < 18) q = pool_op(OP_COUNT);
			else if (r < 19) q = pool_op(OpW'($urandom_range(5, 7)));
			else begin
				q = pool_op(OP_INSERT);
				q.id_high = $urandom(); q.id_middle = rand64(); q.id_low = rand64();
				q.op = OpW'($urandom_range(0, 3));
			end
			send_op(q);
		end
		drain();
	endtask

	task automatic test_backpressure();
		req_t q;
		sender_bursty = 0;
		hold_go = 1;
		for (int i = 0; i < 20; i++) begin
			q = pool_op(i % 2 ? OP_CLOSEST : OP_INSERT);
			send_op(q);
		end
		sender_bursty = 1;
		drain();
	endtask

	// long receiver hold-off, counted in cycles
	initial begin
		wait (hold_go);
		long_hold = 1;
		repeat (300) @(posedge clk);
		long_hold = 0;
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 0;
		end else if (long_hold) begin
			rsp.ready <= 0;
		end else begin
			rsp.ready <= ($urandom_range(0, 99) < 70);
		end
	end

	always @(posedge clk) begin
		rsp_t got, want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = rsp.data;
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_rsp.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %h actual %h", want, got);
				end
			end
		end
	end

	initial begin
		#400000;
		$display("xor_distance_node_table_top regression: fail");
		$finish;
	end

	initial begin
		req.valid = 0; req.data = '0;
		cfg.valid = 0; cfg.data = '0;
		own_hi = 0; own_mid = 0; own_lo = 0; capacity = 8;
		for (int i = 0; i < 8; i++) begin
			tab_valid[i] = 0; tab_id[i] = '0; tab_addr[i] = '0; tab_port[i] = '0;
		end
		for (int i = 0; i < 12; i++) id_pool[i] = {$urandom(), rand64(), rand64()};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_config();
		test_random(100, 8);
		test_backpressure();
		test_random(90, 3);
		test_random(90, 8);
		if (mismatches == 0 && expected_rsp.size() == 0) begin
			$display("xor_distance_node_table_top regression: pass");
		end else begin
			$display("xor_distance_node_table_top regression: fail");
		end
		$finish;
	end
endmodule

// File: filelist.f
hdl/xdnt_pkg.sv
hdl/xdnt_if.sv
hdl/xdnt_datapath.sv
hdl/xdnt_ctrl.sv
hdl/xor_distance_node_table_top.sv
bench/tb_xor_distance_node_table_top.sv
